// ----- rtl/rau_pkg.sv -----
// shared types and codes for the rational arithmetic unit
package rau_pkg;

    localparam int FIELD_BITS = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OPND_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_RES_DEN  = 2'd3
    } status_t;

endpackage

// ----- rtl/rau_if.sv -----
// valid/ready channels for operand beats and result beats
interface rau_in_if;
    logic                 valid;
    logic                 ready;
    rau_pkg::op_t         opcode;
    logic signed [31:0]   a_numerator;
    logic signed [31:0]   a_denominator;
    logic signed [31:0]   b_numerator;
    logic signed [31:0]   b_denominator;

    modport source (output valid, opcode, a_numerator, a_denominator,
                    b_numerator, b_denominator, input ready);
    modport sink   (input valid, opcode, a_numerator, a_denominator,
                    b_numerator, b_denominator, output ready);
endinterface

interface rau_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   result_numerator;
    logic signed [31:0]   result_denominator;
    rau_pkg::status_t     status;

    modport source (output valid, result_numerator, result_denominator, status,
                    input ready);
    modport sink   (input valid, result_numerator, result_denominator, status,
                    output ready);
endinterface

// ----- rtl/rau_divider.sv -----
// restoring unsigned divider, one quotient bit per cycle
module rau_divider #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] quotient,
    output logic [WORD_BITS-1:0] remainder
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] dvs_reg, dvs_next;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[WORD_BITS-1]};
        diff      = shifted - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CW'(WORD_BITS);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = diff[WORD_BITS] ? shifted[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
            quo_next = {quo_reg[WORD_BITS-2:0], ~diff[WORD_BITS]};
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ----- rtl/rational_arith_unit.sv -----
// rational arithmetic unit: gcd-reduced add, sub, mul, div of two fractions
//
// usage: one operand beat on "operands" carries an opcode and two fractions;
// one result beat on "result" carries the reduced fraction and a status.
// operands.ready is high only while the sequencer is idle, so one item is in
// work at a time. each item runs three gcd reductions (operand a, operand b,
// result), every remainder and quotient coming from one shared restoring
// divider, and up to three products from a shift-add multiplier. the time
// per item therefore depends on the data, through the number of euclid
// steps; an operand denominator of zero goes straight to the result.
// the result sits in an output register until taken; while the receiver
// stalls a finished item waits in the sequencer and no new beat is taken.
// reset clears the sequencer and the output valid; nothing else needs it.
module rational_arith_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    rau_in_if.sink operands,
    rau_out_if.source result
);
    import rau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_R = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_GCD   = 11'b00000000010,
        S_GWAIT = 11'b00000000100,
        S_QN    = 11'b00000001000,
        S_QNW   = 11'b00000010000,
        S_QD    = 11'b00000100000,
        S_QDW   = 11'b00001000000,
        S_MSET  = 11'b00010000000,
        S_MRUN  = 11'b00100000000,
        S_COMB  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [1:0]     phase_reg, phase_next;
    logic [1:0]     k_reg, k_next;
    op_t            op_reg, op_next;
    status_t        st_reg, st_next;
    logic [W-1:0]   an_reg, an_next, ad_reg, ad_next;
    logic [W-1:0]   bn_reg, bn_next, bd_reg, bd_next;
    logic [W-1:0]   x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [W-1:0]   p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic [W-1:0]   mc_reg, mc_next, mp_reg, mp_next, acc_reg, acc_next;
    logic [CW-1:0]  mcnt_reg, mcnt_next;

    logic           ovalid_reg, ovalid_next;
    logic [31:0]    onum_reg, onum_next, oden_reg, oden_next;
    status_t        ost_reg, ost_next;

    logic           div_start, div_done;
    logic [W-1:0]   div_a, div_b, div_q, div_r;
    logic [W-1:0]   cur_n, cur_d, sq, rn, rd;
    logic           sq_neg;

    function automatic logic [W-1:0] magn(input logic [W-1:0] v);
        magn = v[W-1] ? (W'(0) - v) : v;
    endfunction

    rau_divider #(.WORD_BITS(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign cur_n = (phase_reg == PH_B) ? bn_reg : an_reg;
    assign cur_d = (phase_reg == PH_B) ? bd_reg : ad_reg;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  rn = p0_reg + p2_reg;
            OP_SUB:  rn = p0_reg - p2_reg;
            default: rn = p0_reg;
        endcase
        rd = p1_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        k_next      = k_reg;
        op_next     = op_reg;
        st_next     = st_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        g_next      = g_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        mc_next     = mc_reg;
        mp_next     = mp_reg;
        acc_next    = acc_reg;
        mcnt_next   = mcnt_reg;
        ovalid_next = ovalid_reg;
        onum_next   = onum_reg;
        oden_next   = oden_reg;
        ost_next    = ost_reg;
        div_start   = 1'b0;
        div_a       = magn(x_reg);
        div_b       = magn(y_reg);
        sq_neg      = 1'b0;
        sq          = div_q;

        if (ovalid_reg && result.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (operands.valid)
                begin
                    op_next = operands.opcode;
                    an_next = W'(operands.a_numerator);
                    ad_next = W'(operands.a_denominator);
                    bn_next = W'(operands.b_numerator);
                    bd_next = W'(operands.b_denominator);
                    x_next  = W'(operands.a_numerator);
                    y_next  = W'(operands.a_denominator);
                    phase_next = PH_A;
                    if (W'(operands.a_denominator) == '0 ||
                        W'(operands.b_denominator) == '0)
                    begin
                        st_next    = ST_OPND_DEN;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (y_reg == '0)
                begin
                    g_next     = x_reg;
                    state_next = S_QN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (div_done)
                begin
                    // remainder takes the dividend's sign
                    x_next     = y_reg;
                    y_next     = x_reg[W-1] ? (W'(0) - div_r) : div_r;
                    state_next = S_GCD;
                end
            end
            S_QN:
            begin
                div_a      = magn(cur_n);
                div_b      = magn(g_reg);
                div_start  = 1'b1;
                state_next = S_QNW;
            end
            S_QNW:
            begin
                sq_neg = cur_n[W-1] ^ g_reg[W-1];
                sq     = sq_neg ? (W'(0) - div_q) : div_q;
                if (div_done)
                begin
                    if (phase_reg == PH_B)
                        bn_next = sq;
                    else
                        an_next = sq;
                    state_next = S_QD;
                end
            end
            S_QD:
            begin
                div_a      = magn(cur_d);
                div_b      = magn(g_reg);
                div_start  = 1'b1;
                state_next = S_QDW;
            end
            S_QDW:
            begin
                sq_neg = cur_d[W-1] ^ g_reg[W-1];
                sq     = sq_neg ? (W'(0) - div_q) : div_q;
                if (div_done)
                begin
                    if (phase_reg == PH_B)
                        bd_next = sq;
                    else
                        ad_next = sq;
                    if (phase_reg == PH_A)
                    begin
                        phase_next = PH_B;
                        x_next     = bn_reg;
                        y_next     = bd_reg;
                        state_next = S_GCD;
                    end
                    else if (phase_reg == PH_B)
                    begin
                        k_next = 2'd0;
                        if (op_reg == OP_DIV && bn_reg == '0)
                        begin
                            st_next    = ST_DIV_ZERO;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_MSET;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_MSET:
            begin
                unique case (k_reg)
                    2'd0:
                    begin
                        mc_next = an_reg;
                        mp_next = (op_reg == OP_MUL) ? bn_reg : bd_reg;
                    end
                    2'd1:
                    begin
                        mc_next = ad_reg;
                        mp_next = (op_reg == OP_DIV) ? bn_reg : bd_reg;
                    end
                    default:
                    begin
                        mc_next = bn_reg;
                        mp_next = ad_reg;
                    end
                endcase
                acc_next   = '0;
                mcnt_next  = CW'(W);
                state_next = S_MRUN;
            end
            S_MRUN:
            begin
                acc_next  = mp_reg[0] ? (acc_reg + mc_reg) : acc_reg;
                mc_next   = {mc_reg[W-2:0], 1'b0};
                mp_next   = {1'b0, mp_reg[W-1:1]};
                mcnt_next = mcnt_reg - 1'b1;
                if (mcnt_reg == CW'(1))
                begin
                    unique case (k_reg)
                        2'd0:    p0_next = acc_next;
                        2'd1:    p1_next = acc_next;
                        default: p2_next = acc_next;
                    endcase
                    k_next = k_reg + 1'b1;
                    if (k_reg == 2'd2 ||
                        (k_reg == 2'd1 && (op_reg == OP_MUL || op_reg == OP_DIV)))
                        state_next = S_COMB;
                    else
                        state_next = S_MSET;
                end
            end
            S_COMB:
            begin
                if (rd == '0)
                begin
                    st_next    = ST_RES_DEN;
                    state_next = S_DONE;
                end
                else
                begin
                    an_next    = rn;
                    ad_next    = rd;
                    x_next     = rn;
                    y_next     = rd;
                    phase_next = PH_R;
                    state_next = S_GCD;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    ost_next    = st_reg;
                    if (st_reg == ST_OK)
                    begin
                        onum_next = 32'(signed'(an_reg));
                        oden_next = 32'(signed'(ad_reg));
                    end
                    else
                    begin
                        onum_next = '0;
                        oden_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        k_reg     <= k_next;
        op_reg    <= op_next;
        st_reg    <= st_next;
        an_reg    <= an_next;
        ad_reg    <= ad_next;
        bn_reg    <= bn_next;
        bd_reg    <= bd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        g_reg     <= g_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        mc_reg    <= mc_next;
        mp_reg    <= mp_next;
        acc_reg   <= acc_next;
        mcnt_reg  <= mcnt_next;
        onum_reg  <= onum_next;
        oden_reg  <= oden_next;
        ost_reg   <= ost_next;
    end

    assign operands.ready            = (state_reg == S_IDLE);
    assign result.valid              = ovalid_reg;
    assign result.result_numerator   = onum_reg;
    assign result.result_denominator = oden_reg;
    assign result.status             = ost_reg;

    // an accepted beat keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (operands.valid && operands.ready) |=> !operands.ready)
        else $error("ready did not drop after an operand beat");

    // error results carry a zero fraction
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ost_reg != ST_OK) |-> (onum_reg == '0 && oden_reg == '0))
        else $error("error result with nonzero fraction");

    // a divider start is always followed by a state that waits for it
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_GWAIT || state_reg == S_QNW || state_reg == S_QDW))
        else $error("divider started outside a wait sequence");

    // a result is only loaded when the output slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !result.ready) |=> (ovalid_reg && $stable(onum_reg)))
        else $error("pending result overwritten");
endmodule
